FILE: rtl/fat_chain_allocator_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef FAT_CHAIN_ALLOCATOR_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_MACROS_SVH

// Clocked check, off while reset is asserted.
`define FCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fca_pkg.sv
package fca_pkg;

  typedef enum logic [2:0] {
    MODE_FORMAT  = 3'd0,
    MODE_ALLOC   = 3'd1,
    MODE_EXTEND  = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_LOOKUP  = 3'd4,
    MODE_COUNT   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_LINK = 2'd0,
    KIND_EOC  = 2'd1,
    KIND_FREE = 2'd2,
    KIND_RSV  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_COUNT = 2'd1,
    STAT_CHAIN = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_TOTAL = 1'b0,
    CFG_FIRST = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_FMT, ST_IDLE, ST_DISP, ST_RC_RD, ST_RC_EV, ST_AL_RD, ST_AL_EV, ST_AL_END,
    ST_EX_LINK, ST_WK_RD, ST_WK_EV, ST_RL_RD, ST_RL_EV, ST_LK_RD, ST_LK_EV, ST_DONE
  } state_t;

  localparam int BLOCKS  = 4096;

  localparam int MODE_W  = 3;
  localparam int BLOCK_W = 12;
  localparam int COUNT_W = 13;
  localparam int CFG_W   = 13;

  localparam logic [CFG_W-1:0] TOTAL_RST = 13'd4096;
  localparam logic [CFG_W-1:0] FIRST_RST = 13'd154;

endpackage

FILE: rtl/fca_if.sv
interface fca_in_if;
  import fca_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [BLOCK_W-1:0]   block;
  logic [COUNT_W-1:0]   count;
  modport source (output valid, mode, block, count, input ready);
  modport sink   (input valid, mode, block, count, output ready);
endinterface

interface fca_out_if;
  import fca_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BLOCK_W-1:0]   first_block;
  logic [COUNT_W-1:0]   block_count;
  logic [1:0]           entry_kind;
  logic [1:0]           status;
  modport source (output valid, first_block, block_count, entry_kind, status, input ready);
  modport sink   (input valid, first_block, block_count, entry_kind, status, output ready);
endinterface

FILE: rtl/fat_chain_allocator.sv
// Block allocation table engine. One command per in_ch transaction (format,
// allocate, extend, release, next lookup, count free); exactly one result per
// command on out_ch. Both channels use valid/ready.
// The table lives in a single-port-write, registered-read memory of BLOCKS
// entries; each table step is an address state, then an evaluate/write state.
// Format writes every entry; allocate scans the table for free blocks;
// extend walks the chain to its end-of-chain entry before that scan; release
// frees one block per chain step. The free total is recounted lazily before
// the next allocate, extend or count free that follows a table change or a
// cfg write.
// Reset: a format pass over all BLOCKS entries runs with the reset register values;
// in_ch.ready stays low until it is done. cfg writes are taken at any time.
// A finished result sits in the output register; a new command may be taken
// while it waits, but the next result holds until out_ch.ready frees the slot.
module fat_chain_allocator
  import fca_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  fca_in_if.sink            in_ch,
  fca_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int IW = $clog2(BLOCKS);
  localparam int CW = IW + 1;
  localparam int EW = IW + 2;

  `include "fat_chain_allocator_macros.svh"

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   total_r, first_r;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      steps_r, steps_nxt;
  logic [CW-1:0]      taken_r, taken_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      prev_r, prev_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic [CW-1:0]      free_r, free_nxt;
  logic               dirty_r, dirty_nxt;
  logic               boot_r, boot_nxt;

  logic [IW-1:0]      res_idx_r, res_idx_nxt;
  logic [CW-1:0]      res_cnt_r, res_cnt_nxt;
  kind_t              res_kind_r, res_kind_nxt;
  status_t            res_st_r, res_st_nxt;

  logic               out_valid_r;
  logic [BLOCK_W-1:0] out_idx_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [1:0]         out_kind_r, out_st_r;

  logic [EW-1:0]      mem [BLOCKS];
  logic [EW-1:0]      rd_r;
  logic               mem_we;
  logic [IW-1:0]      mem_wa, mem_ra;
  logic [EW-1:0]      mem_wd;

  logic [CW-1:0]      eff_t;
  kind_t              rd_kind;
  logic [IW-1:0]      rd_link;
  logic               in_fire, out_fire, fa_ge_t, cnt_bad, link_oob;
  logic               blk_in_t, blk_in_mem, idx_last, steps_last, fmt_last, need_rc;

  always_comb begin
    if (32'(total_r) < 32'd2) begin
      eff_t = CW'(2);
    end else if (32'(total_r) > 32'(BLOCKS)) begin
      eff_t = CW'(BLOCKS);
    end else begin
      eff_t = CW'(total_r);
    end
  end

  assign rd_kind    = kind_t'(rd_r[EW-1:IW]);
  assign rd_link    = rd_r[IW-1:0];
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_fire   = !out_valid_r || out_ch.ready;
  assign fa_ge_t    = 32'(first_r) >= 32'(eff_t);
  assign cnt_bad    = (cnt_r == '0) || (32'(cnt_r) > 32'(free_r));
  assign link_oob   = 32'(rd_link) >= 32'(eff_t);
  assign blk_in_t   = 32'(blk_r) < 32'(eff_t);
  assign blk_in_mem = 32'(blk_r) < 32'(BLOCKS);
  assign idx_last   = (32'(idx_r) + 32'd1) == 32'(eff_t);
  assign steps_last = (32'(steps_r) + 32'd1) == 32'(eff_t);
  assign fmt_last   = idx_r[IW-1:0] == IW'(BLOCKS - 1);
  assign need_rc    = dirty_r && (mode_r == MODE_ALLOC || mode_r == MODE_EXTEND ||
                                  mode_r == MODE_COUNT);

  function automatic logic [EW-1:0] fmt_entry(input logic [CW-1:0] i,
                                               input logic [CW-1:0] t,
                                               input logic [CFG_W-1:0] fa);
    kind_t k;
    if (32'(i) >= 32'(t)) begin
      k = KIND_RSV;
    end else if (i == '0 || 32'(i) == 32'(t) - 32'd1) begin
      k = KIND_EOC;
    end else if (32'(i) < 32'(fa)) begin
      k = KIND_RSV;
    end else begin
      k = KIND_FREE;
    end
    return {k, IW'(0)};
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FMT:     if (fmt_last) state_nxt = boot_r ? ST_IDLE : ST_DONE;
      ST_IDLE:    if (in_fire) state_nxt = ST_DISP;
      ST_DISP: begin
        priority if (mode_r == MODE_FORMAT) begin
          state_nxt = ST_FMT;
        end else if (need_rc) begin
          state_nxt = fa_ge_t ? ST_DISP : ST_RC_RD;
        end else begin
          unique case (mode_r)
            MODE_ALLOC:   state_nxt = cnt_bad ? ST_DONE : ST_AL_RD;
            MODE_EXTEND:  state_nxt = blk_in_t ? ST_WK_RD : ST_DONE;
            MODE_RELEASE: state_nxt = blk_in_t ? ST_RL_RD : ST_DONE;
            MODE_LOOKUP:  state_nxt = blk_in_mem ? ST_LK_RD : ST_DONE;
            default:      state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RC_RD:   state_nxt = ST_RC_EV;
      ST_RC_EV:   state_nxt = idx_last ? ST_DISP : ST_RC_RD;
      ST_AL_RD:   state_nxt = ST_AL_EV;
      ST_AL_EV: begin
        if ((rd_kind == KIND_FREE && (32'(taken_r) + 32'd1) == 32'(cnt_r)) || idx_last) begin
          state_nxt = ST_AL_END;
        end else begin
          state_nxt = ST_AL_RD;
        end
      end
      ST_AL_END:  state_nxt = (mode_r == MODE_EXTEND) ? ST_EX_LINK : ST_DONE;
      ST_EX_LINK: state_nxt = ST_DONE;
      ST_WK_RD:   state_nxt = ST_WK_EV;
      ST_WK_EV: begin
        priority if (rd_kind == KIND_EOC) begin
          state_nxt = cnt_bad ? ST_DONE : ST_AL_RD;
        end else if (rd_kind != KIND_LINK || link_oob || steps_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WK_RD;
        end
      end
      ST_RL_RD:   state_nxt = ST_RL_EV;
      ST_RL_EV: begin
        if (rd_kind != KIND_LINK || link_oob || steps_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RL_RD;
        end
      end
      ST_LK_RD:   state_nxt = ST_LK_EV;
      ST_LK_EV:   state_nxt = ST_DONE;
      ST_DONE:    if (out_fire) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    mode_nxt     = mode_r;
    blk_nxt      = blk_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    steps_nxt    = steps_r;
    taken_nxt    = taken_r;
    head_nxt     = head_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    free_nxt     = free_r;
    dirty_nxt    = dirty_r;
    boot_nxt     = boot_r;
    res_idx_nxt  = res_idx_r;
    res_cnt_nxt  = res_cnt_r;
    res_kind_nxt = res_kind_r;
    res_st_nxt   = res_st_r;
    mem_we       = 1'b0;
    mem_wa       = prev_r;
    mem_wd       = '0;
    mem_ra       = idx_r[IW-1:0];
    unique case (state_r)
      ST_FMT: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r[IW-1:0];
        mem_wd  = fmt_entry(idx_r, eff_t, first_r);
        idx_nxt = idx_r + CW'(1);
        if (fmt_last) begin
          boot_nxt  = 1'b0;
          dirty_nxt = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt     = in_ch.mode;
          blk_nxt      = in_ch.block;
          cnt_nxt      = in_ch.count;
          res_idx_nxt  = '0;
          res_cnt_nxt  = '0;
          res_kind_nxt = KIND_LINK;
          res_st_nxt   = STAT_OK;
        end
      end
      ST_DISP: begin
        priority if (mode_r == MODE_FORMAT) begin
          idx_nxt = '0;
        end else if (need_rc) begin
          free_nxt = '0;
          if (fa_ge_t) begin
            dirty_nxt = 1'b0;
          end else begin
            idx_nxt = CW'(first_r);
          end
        end else begin
          unique case (mode_r)
            MODE_ALLOC: begin
              if (cnt_bad) begin
                res_st_nxt = STAT_COUNT;
              end else begin
                idx_nxt   = CW'(first_r);
                taken_nxt = '0;
              end
            end
            MODE_EXTEND, MODE_RELEASE: begin
              if (blk_in_t) begin
                cur_nxt   = IW'(blk_r);
                steps_nxt = '0;
              end else begin
                res_st_nxt = STAT_CHAIN;
              end
            end
            MODE_LOOKUP: if (!blk_in_mem) res_kind_nxt = KIND_RSV;
            MODE_COUNT:  res_cnt_nxt = free_r;
            default: ;
          endcase
        end
      end
      ST_RC_EV: begin
        if (rd_kind == KIND_FREE) free_nxt = free_r + CW'(1);
        idx_nxt = idx_r + CW'(1);
        if (idx_last) dirty_nxt = 1'b0;
      end
      ST_AL_EV: begin
        if (rd_kind == KIND_FREE) begin
          if (taken_r == '0) begin
            head_nxt = idx_r[IW-1:0];
          end else begin
            mem_we = 1'b1;
            mem_wd = {KIND_LINK, idx_r[IW-1:0]};
          end
          prev_nxt  = idx_r[IW-1:0];
          taken_nxt = taken_r + CW'(1);
        end
        idx_nxt = idx_r + CW'(1);
      end
      ST_AL_END: begin
        mem_we      = 1'b1;
        mem_wd      = {KIND_EOC, IW'(0)};
        res_idx_nxt = head_r;
      end
      ST_EX_LINK: begin
        mem_we = 1'b1;
        mem_wa = cur_r;
        mem_wd = {KIND_LINK, head_r};
      end
      ST_WK_RD, ST_RL_RD: mem_ra = cur_r;
      ST_WK_EV: begin
        priority if (rd_kind == KIND_EOC) begin
          if (cnt_bad) begin
            res_st_nxt = STAT_COUNT;
          end else begin
            idx_nxt   = CW'(first_r);
            taken_nxt = '0;
          end
        end else if (rd_kind != KIND_LINK || link_oob || steps_last) begin
          res_st_nxt = STAT_CHAIN;
        end else begin
          cur_nxt   = rd_link;
          steps_nxt = steps_r + CW'(1);
        end
      end
      ST_RL_EV: begin
        if (rd_kind == KIND_EOC || rd_kind == KIND_LINK) begin
          mem_we      = 1'b1;
          mem_wa      = cur_r;
          mem_wd      = {KIND_FREE, IW'(0)};
          res_cnt_nxt = res_cnt_r + CW'(1);
        end else if (steps_r == '0) begin
          // Free or reserved start: not a chain.
          res_st_nxt = STAT_CHAIN;
        end
        if (rd_kind == KIND_LINK && !link_oob) begin
          cur_nxt   = rd_link;
          steps_nxt = steps_r + CW'(1);
        end
      end
      ST_LK_RD: mem_ra = IW'(blk_r);
      ST_LK_EV: begin
        res_kind_nxt = rd_kind;
        if (rd_kind == KIND_LINK) res_idx_nxt = rd_link;
      end
      ST_DONE: begin
        if (out_fire && 32'(mode_r) <= 32'(MODE_RELEASE)) dirty_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FMT;
      total_r     <= TOTAL_RST;
      first_r     <= FIRST_RST;
      idx_r       <= '0;
      dirty_r     <= 1'b1;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      boot_r  <= boot_nxt;
      // A register change moves the counted range: force a recount.
      if (cfg_we) begin
        dirty_r <= 1'b1;
        unique case (cfg_idx_t'(cfg_index))
          CFG_TOTAL: total_r <= cfg_wdata;
          CFG_FIRST: first_r <= cfg_wdata;
          default: ;
        endcase
      end else begin
        dirty_r <= dirty_nxt;
      end
      if (state_r == ST_DONE && out_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    blk_r      <= blk_nxt;
    cnt_r      <= cnt_nxt;
    steps_r    <= steps_nxt;
    taken_r    <= taken_nxt;
    head_r     <= head_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    free_r     <= free_nxt;
    res_idx_r  <= res_idx_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_kind_r <= res_kind_nxt;
    res_st_r   <= res_st_nxt;
    if (state_r == ST_DONE && out_fire) begin
      out_idx_r  <= BLOCK_W'(res_idx_r);
      out_cnt_r  <= COUNT_W'(res_cnt_r);
      out_kind_r <= res_kind_r;
      out_st_r   <= res_st_r;
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.first_block = out_idx_r;
  assign out_ch.block_count = out_cnt_r;
  assign out_ch.entry_kind  = out_kind_r;
  assign out_ch.status      = out_st_r;

  `FCA_ASSERT(a_accept_dispatch, in_fire |=> state_r == ST_DISP, "accept did not dispatch")
  `FCA_ASSERT(a_scan_in_range, state_r == ST_AL_EV |-> 32'(idx_r) < 32'(eff_t), "scan past total")
  `FCA_ASSERT(a_err_no_data, out_valid_r && out_st_r != STAT_OK |-> out_cnt_r == '0 && out_kind_r == KIND_LINK, "error result carries data")
  `FCA_ASSERT_ALWAYS(a_reset_fmt, !rst_n |=> state_r == ST_FMT && !out_valid_r, "reset did not start format")

endmodule
